// ===== src/lcg_pkg.sv =====
`default_nettype none

package lcg_pkg;

	// Fixed field widths
	localparam int FIELD_W = 16;
	localparam int CNT_W = 17;
	localparam int PROD_W = 2 * CNT_W;
	localparam int DIV_STEPS = CNT_W;
	localparam int REG_IDX_W = 3;

	// Defaults for the top-level parameters
	localparam int INDEX_BITS_DEF = 16;
	localparam int VALUE_BITS_DEF = 16;

	// Register reset values
	localparam logic [CNT_W-1:0] TABLE_ENTRIES_RST = 17'd256;
	localparam logic [FIELD_W-1:0] TOP_VALUE_RST = 16'd255;
	localparam logic [FIELD_W-1:0] END_Y_RST = 16'd255;

	typedef enum logic [2:0] {
		MODE_RAMP = 3'd0,
		MODE_INV  = 3'd1,
		MODE_SIGN = 3'd2,
		MODE_CLIP = 3'd3,
		MODE_KNEE = 3'd4
	} mode_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MODE      = 3'd0,
		REG_ENTRIES   = 3'd1,
		REG_TOP       = 3'd2,
		REG_KNEE1_X   = 3'd3,
		REG_KNEE1_Y   = 3'd4,
		REG_KNEE2_X   = 3'd5,
		REG_KNEE2_Y   = 3'd6,
		REG_END_Y     = 3'd7
	} reg_idx_t;

	// Per-item data that rides alongside the divider
	typedef struct packed {
		logic [FIELD_W-1:0] idx;
		logic               wr;
		logic               neg;
		logic               lower;
		logic [FIELD_W-1:0] base;
	} side_t;

endpackage

`default_nettype wire

// ===== src/lcg_div_pipe.sv =====
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage. The dividend must
// be below den * 2^DIV_STEPS, so the quotient fits in DIV_STEPS bits.
module lcg_div_pipe (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic [lcg_pkg::PROD_W-1:0]     in_num,
	input  wire logic [lcg_pkg::CNT_W-1:0]      in_den,
	input  wire lcg_pkg::side_t                 in_side,
	output logic                                out_valid,
	output logic [lcg_pkg::DIV_STEPS-1:0]       out_quot,
	output lcg_pkg::side_t                      out_side
);

	localparam int STEPS = lcg_pkg::DIV_STEPS;
	localparam int W = lcg_pkg::CNT_W;

	// Stage k holds the state after k quotient bits.
	logic                 valid_s [1:STEPS];
	logic [W-1:0]         rem_s   [1:STEPS];
	logic [STEPS-1:0]     lowq_s  [1:STEPS];
	logic [W-1:0]         den_s   [1:STEPS];
	lcg_pkg::side_t       side_s  [1:STEPS];

	genvar k;
	generate
		for (k = 0; k < STEPS; k++) begin : g_step
			logic             v_in;
			logic [W-1:0]     rem_in;
			logic [STEPS-1:0] lowq_in;
			logic [W-1:0]     den_in;
			lcg_pkg::side_t   side_in;
			logic [W:0]       trial;
			logic             fits;

			if (k == 0) begin : g_src_in
				assign v_in = in_valid;
				assign rem_in = in_num[lcg_pkg::PROD_W-1:STEPS];
				assign lowq_in = in_num[STEPS-1:0];
				assign den_in = in_den;
				assign side_in = in_side;
			end else begin : g_src_reg
				assign v_in = valid_s[k];
				assign rem_in = rem_s[k];
				assign lowq_in = lowq_s[k];
				assign den_in = den_s[k];
				assign side_in = side_s[k];
			end

			// Shift in the next dividend bit and try to subtract.
			assign trial = {rem_in, lowq_in[STEPS-1]};
			assign fits = trial >= {1'b0, den_in};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[k+1] <= 1'b0;
				end else begin
					valid_s[k+1] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (fits) begin
					rem_s[k+1] <= W'(trial - {1'b0, den_in});
				end else begin
					rem_s[k+1] <= trial[W-1:0];
				end
				lowq_s[k+1] <= {lowq_in[STEPS-2:0], fits};
				den_s[k+1] <= den_in;
				side_s[k+1] <= side_in;
			end
		end
	endgenerate

	assign out_valid = valid_s[STEPS];
	assign out_quot = lowq_s[STEPS];
	assign out_side = side_s[STEPS];

endmodule

`default_nettype wire

// ===== src/lut_curve_generator.sv =====
`default_nettype none

// Lookup-table curve generator.
// Each beat on the command channel (start while busy is low) carries one
// table index; the block answers with exactly one result beat carrying the
// index, the curve value at that index and a flag telling whether the curve
// defines the entry. Results appear on done for one cycle each, in order.
// An index is taken in every cycle: the pipeline has no stall path, so busy
// is only high while the block comes out of reset.
// The path from index to done is registered in order: the operand stage,
// the multiplier stage, 17 stages of the restoring divider (one quotient
// bit each) and the result register.
// The configuration port writes one register per cycle with cfg_write high;
// the user must change them only while no index is in flight; not enforced.
// Asynchronous reset empties the pipeline and restores the register defaults:
// ramp mode, 256 entries, top value 255, end value 255, knees at zero.
// The receiver cannot hold results off; a result is gone after its cycle.
module lut_curve_generator #(
	parameter int INDEX_BITS = lcg_pkg::INDEX_BITS_DEF,
	parameter int VALUE_BITS = lcg_pkg::VALUE_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [lcg_pkg::FIELD_W-1:0]        entry_index,
	input  wire logic                               cfg_write,
	input  wire logic [lcg_pkg::REG_IDX_W-1:0]      cfg_index,
	input  wire logic [lcg_pkg::CNT_W-1:0]          cfg_data,
	output logic                                    done,
	output logic [lcg_pkg::FIELD_W-1:0]             entry_index_out,
	output logic [lcg_pkg::FIELD_W-1:0]             entry_value,
	output logic                                    written
);

	localparam int FW = lcg_pkg::FIELD_W;
	localparam int CW = lcg_pkg::CNT_W;
	localparam int PW = lcg_pkg::PROD_W;
	localparam int VW = CW + 2;
	localparam logic [FW-1:0] IDX_MASK = FW'((32'd1 << INDEX_BITS) - 1);
	localparam logic [VW-1:0] VMAX = VW'((32'd1 << VALUE_BITS) - 1);

	// Configuration registers
	lcg_pkg::mode_t  mode_q;
	logic [CW-1:0]   table_entries_q;
	logic [FW-1:0]   top_value_q;
	logic [FW-1:0]   knee1_x_q;
	logic [FW-1:0]   knee1_y_q;
	logic [FW-1:0]   knee2_x_q;
	logic [FW-1:0]   knee2_y_q;
	logic [FW-1:0]   end_y_q;
	logic            busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= lcg_pkg::MODE_RAMP;
			table_entries_q <= lcg_pkg::TABLE_ENTRIES_RST;
			top_value_q <= lcg_pkg::TOP_VALUE_RST;
			knee1_x_q <= '0;
			knee1_y_q <= '0;
			knee2_x_q <= '0;
			knee2_y_q <= '0;
			end_y_q <= lcg_pkg::END_Y_RST;
		end else if (cfg_write) begin
			unique case (lcg_pkg::reg_idx_t'(cfg_index))
				lcg_pkg::REG_MODE:    mode_q <= lcg_pkg::mode_t'(cfg_data[2:0]);
				lcg_pkg::REG_ENTRIES: table_entries_q <= cfg_data;
				lcg_pkg::REG_TOP:     top_value_q <= cfg_data[FW-1:0];
				lcg_pkg::REG_KNEE1_X: knee1_x_q <= cfg_data[FW-1:0];
				lcg_pkg::REG_KNEE1_Y: knee1_y_q <= cfg_data[FW-1:0];
				lcg_pkg::REG_KNEE2_X: knee2_x_q <= cfg_data[FW-1:0];
				lcg_pkg::REG_KNEE2_Y: knee2_y_q <= cfg_data[FW-1:0];
				lcg_pkg::REG_END_Y:   end_y_q <= cfg_data[FW-1:0];
				default: ;
			endcase
		end
	end

	// Busy only while leaving reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end
	assign busy = busy_q;

	// Operand stage: pick multiplier factors, divisor and sideband per mode.
	logic [FW-1:0]        idx;
	logic [CW-1:0]        idx_x, n, n1, m1, x1, x2;
	logic                 in_range, knees_ok, seg1, seg2, seg3;
	logic signed [CW-1:0] dy1, dy2, dy3, dy;
	logic [CW-1:0]        op_a, op_b, op_den;
	lcg_pkg::side_t       side;

	always_comb begin
		idx = entry_index & IDX_MASK;
		idx_x = {1'b0, idx};
		n = table_entries_q;
		n1 = n - CW'(1);
		m1 = {1'b0, top_value_q} + CW'(1);
		x1 = {1'b0, knee1_x_q};
		x2 = {1'b0, knee2_x_q};
		in_range = idx_x < n;
		knees_ok = (x1 < n) && (x2 < n) && (x2 >= x1);
		seg1 = (x1 != '0) && (idx_x <= x1);
		seg2 = (x2 > x1) && (idx_x > x1) && (idx_x <= x2);
		seg3 = (x2 < n1) && (idx_x > x2);
		dy1 = $signed({1'b0, knee1_y_q});
		dy2 = $signed({1'b0, knee2_y_q}) - $signed({1'b0, knee1_y_q});
		dy3 = $signed({1'b0, end_y_q}) - $signed({1'b0, knee2_y_q});

		side.idx = idx;
		side.lower = idx_x < (n >> 1);
		side.neg = 1'b0;
		side.base = '0;
		side.wr = 1'b0;
		op_a = idx_x;
		op_b = m1;
		op_den = n;
		dy = dy1;

		unique case (mode_q)
			lcg_pkg::MODE_RAMP, lcg_pkg::MODE_SIGN, lcg_pkg::MODE_CLIP: begin
				side.wr = in_range;
			end
			lcg_pkg::MODE_INV: begin
				op_a = n1 - idx_x;
				side.wr = in_range;
			end
			lcg_pkg::MODE_KNEE: begin
				// First matching segment wins.
				priority if (seg1) begin
					op_den = x1;
					dy = dy1;
				end else if (seg2) begin
					op_a = idx_x - x1;
					op_den = x2 - x1;
					dy = dy2;
					side.base = knee1_y_q;
				end else begin
					op_a = idx_x - x2;
					op_den = n1 - x2;
					dy = dy3;
					side.base = knee2_y_q;
				end
				side.neg = dy[CW-1];
				op_b = dy[CW-1] ? CW'(-dy) : CW'(dy);
				side.wr = in_range && knees_ok && (seg1 || seg2 || seg3);
			end
			default: begin
				side.wr = 1'b0;
			end
		endcase
	end

	// Stage 1: operands.
	logic           valid_s1;
	logic [CW-1:0]  a_s1, b_s1, den_s1;
	lcg_pkg::side_t side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy_q;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= op_a;
		b_s1 <= op_b;
		den_s1 <= op_den;
		side_s1 <= side;
	end

	// Stage 2: product.
	logic           valid_s2;
	logic [PW-1:0]  prod_s2;
	logic [CW-1:0]  den_s2;
	lcg_pkg::side_t side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PW'(a_s1) * PW'(b_s1);
		den_s2 <= den_s1;
		side_s2 <= side_s1;
	end

	// Divider stages.
	logic                               dv_valid;
	logic [lcg_pkg::DIV_STEPS-1:0]      dv_quot;
	lcg_pkg::side_t                     dv_side;

	lcg_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.in_num    (prod_s2),
		.in_den    (den_s2),
		.in_side   (side_s2),
		.out_valid (dv_valid),
		.out_quot  (dv_quot),
		.out_side  (dv_side)
	);

	// Finish stage: apply the curve, clamp and saturate.
	logic [FW-2:0]        half;
	logic [VW-1:0]        q_x, val, val_sat;
	logic signed [VW-1:0] knee_sum;

	always_comb begin
		half = top_value_q[FW-1:1];
		q_x = VW'(dv_quot);
		knee_sum = $signed({3'b0, dv_side.base}) +
			(dv_side.neg ? -$signed(q_x) : $signed(q_x));
		val = '0;
		unique case (mode_q)
			lcg_pkg::MODE_RAMP, lcg_pkg::MODE_INV: begin
				val = q_x;
			end
			lcg_pkg::MODE_SIGN: begin
				if (dv_side.lower) begin
					val = q_x + VW'(half);
				end else if (q_x >= VW'(half)) begin
					val = q_x - VW'(half);
				end else begin
					val = '0;
				end
			end
			lcg_pkg::MODE_CLIP: begin
				if (q_x <= VW'(knee1_x_q)) begin
					val = VW'(knee1_x_q);
				end else if (q_x >= VW'(knee1_y_q)) begin
					val = VW'(knee1_y_q);
				end else begin
					val = q_x;
				end
			end
			lcg_pkg::MODE_KNEE: begin
				val = knee_sum[VW-1] ? '0 : VW'(knee_sum);
			end
			default: begin
				val = '0;
			end
		endcase
		if (!dv_side.wr) begin
			val_sat = '0;
		end else if (val > VMAX) begin
			val_sat = VMAX;
		end else begin
			val_sat = val;
		end
	end

	// Result register: each result beat lasts one cycle.
	logic          done_q;
	logic [FW-1:0] idx_out_q, value_q;
	logic          written_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		idx_out_q <= dv_side.idx;
		value_q <= val_sat[FW-1:0];
		written_q <= dv_side.wr;
	end

	assign done = done_q;
	assign entry_index_out = idx_out_q;
	assign entry_value = value_q;
	assign written = written_q;

endmodule

`default_nettype wire
